// ----- design/scd_pkg.sv -----
// Package for the serial command detector: codes, field types and match tables.
// Used by the channel interfaces, the scanner core and the top level.
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

  // line buffer depth and the width of the stored-length count
  localparam int unsigned LINE_SLOTS = 80;
  localparam int unsigned LINE_W     = $clog2(LINE_SLOTS);
  localparam int unsigned TARGET_LEN = 14;

  // characters with a meaning of their own
  localparam logic [7:0] CHAR_LF = 8'h0A;
  localparam logic [7:0] CHAR_CR = 8'h0D;
  localparam logic [7:0] CHAR_C  = 8'h43;

  // result event codes
  typedef enum logic [2:0] {
    EV_SHOT     = 3'd0,
    EV_DISPATCH = 3'd1,
    EV_UNKNOWN  = 3'd2,
    EV_REFUSED  = 3'd3,
    EV_PAYLOAD  = 3'd4
  } scd_event_e;

  // dispatched command codes
  typedef enum logic [2:0] {
    CMD_STATUS = 3'd0,
    CMD_A      = 3'd1,
    CMD_K      = 3'd2,
    CMD_W      = 3'd3,
    CMD_R      = 3'd4,
    CMD_N      = 3'd5,
    CMD_T      = 3'd6
  } scd_command_e;

  // scanner phase, one-hot
  typedef enum logic [2:0] {
    PH_SCAN    = 3'b001,
    PH_CMD     = 3'b010,
    PH_PAYLOAD = 3'b100
  } scd_phase_e;

  // one input item
  typedef struct packed {
    logic       cmd;
    logic [7:0] rx_byte;
    logic       allowed;
  } scd_item_t;

  // one result item
  typedef struct packed {
    logic [2:0] event_res;
    logic [2:0] command;
    logic [7:0] payload;
  } scd_res_t;

  // bytes of the magic word, by match position
  function automatic logic [7:0] magic_char(input logic [1:0] idx);
    logic [7:0] c;
    case (idx)
      2'd0:    c = 8'h43; // C
      2'd1:    c = 8'h4D; // M
      2'd2:    c = 8'h4E; // N
      2'd3:    c = 8'h44; // D
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // bytes of the screenshot line, by position
  function automatic logic [7:0] target_char(input logic [LINE_W-1:0] idx);
    logic [7:0] c;
    case (idx)
      LINE_W'(0):  c = 8'h43; // C
      LINE_W'(1):  c = 8'h4D; // M
      LINE_W'(2):  c = 8'h44; // D
      LINE_W'(3):  c = 8'h3A; // :
      LINE_W'(4):  c = 8'h53; // S
      LINE_W'(5):  c = 8'h43; // C
      LINE_W'(6):  c = 8'h52; // R
      LINE_W'(7):  c = 8'h45; // E
      LINE_W'(8):  c = 8'h45; // E
      LINE_W'(9):  c = 8'h4E; // N
      LINE_W'(10): c = 8'h53; // S
      LINE_W'(11): c = 8'h48; // H
      LINE_W'(12): c = 8'h4F; // O
      LINE_W'(13): c = 8'h54; // T
      default:     c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- design/scd_in_if.sv -----
// Input channel of the serial command detector: valid/ready plus one item.
// Depends on scd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface scd_in_if;
  import scd_pkg::*;

  logic       valid;
  logic       ready;
  logic       cmd;
  logic [7:0] rx_byte;
  logic       allowed;

  modport source (output valid, cmd, rx_byte, allowed, input ready);
  modport sink   (input valid, cmd, rx_byte, allowed, output ready);
endinterface

`default_nettype wire

// ----- design/scd_out_if.sv -----
// Result channel of the serial command detector: valid/ready plus one result.
// Depends on scd_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface scd_out_if;
  import scd_pkg::*;

  logic       valid;
  logic       ready;
  logic [2:0] event_res;
  logic [2:0] command;
  logic [7:0] payload;

  modport source (output valid, event_res, command, payload, input ready);
  modport sink   (input valid, event_res, command, payload, output ready);
endinterface

`default_nettype wire

// ----- design/scd_core.sv -----
// Scanner core: magic, screenshot-line and command state, next-state and result logic.
// Depends on scd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scd_core import scd_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire scd_item_t item_i,
  input  wire logic      fire_i,
  output logic           res_valid_o,
  output scd_res_t       res_o
);

  scd_phase_e        phase_q, phase_d;
  logic [1:0]        magic_q, magic_d;
  logic [LINE_W-1:0] len_q, len_d;
  logic              match_q, match_d;

  logic       magic_hit;
  logic [2:0] letter_code;
  logic       letter_ok;

  assign magic_hit = (item_i.rx_byte == magic_char(magic_q));

  // command letter decode
  always_comb begin
    letter_ok   = 1'b1;
    letter_code = CMD_STATUS;
    case (item_i.rx_byte)
      8'h53:   letter_code = CMD_STATUS; // S
      8'h41:   letter_code = CMD_A;
      8'h4B:   letter_code = CMD_K;
      8'h57:   letter_code = CMD_W;
      8'h52:   letter_code = CMD_R;
      8'h4E:   letter_code = CMD_N;
      8'h54:   letter_code = CMD_T;
      default: letter_ok   = 1'b0;
    endcase
  end

  // next state and result for the item in the input register
  always_comb begin
    phase_d     = phase_q;
    magic_d     = magic_q;
    len_d       = len_q;
    match_d     = match_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    case (phase_q)
      PH_PAYLOAD: begin
        if (item_i.cmd) begin
          phase_d = PH_SCAN;
        end else begin
          res_valid_o     = 1'b1;
          res_o.event_res = EV_PAYLOAD;
          res_o.payload   = item_i.rx_byte;
        end
      end
      PH_CMD: begin
        if (!item_i.cmd) begin
          phase_d     = PH_SCAN;
          res_valid_o = 1'b1;
          if (!letter_ok) begin
            res_o.event_res = EV_UNKNOWN;
          end else if (letter_code == CMD_STATUS) begin
            res_o.event_res = item_i.allowed ? EV_DISPATCH : EV_REFUSED;
          end else begin
            phase_d         = PH_PAYLOAD;
            res_o.event_res = EV_DISPATCH;
            res_o.command   = letter_code;
          end
        end
      end
      default: begin
        if (!item_i.cmd) begin
          phase_d = PH_SCAN;
          if (magic_hit && magic_q == 2'd3) begin
            // magic complete: line restarts, await command letter
            magic_d = 2'd0;
            len_d   = '0;
            match_d = 1'b1;
            phase_d = PH_CMD;
          end else begin
            magic_d = magic_hit ? magic_q + 2'd1
                                : ((item_i.rx_byte == CHAR_C) ? 2'd1 : 2'd0);
            if (item_i.rx_byte == CHAR_LF) begin
              // end of line: screenshot on an exact match
              if (match_q && len_q == LINE_W'(TARGET_LEN)) begin
                res_valid_o     = 1'b1;
                res_o.event_res = EV_SHOT;
              end
              len_d   = '0;
              match_d = 1'b1;
            end else if (item_i.rx_byte != CHAR_CR) begin
              if (len_q < LINE_W'(LINE_SLOTS - 1)) begin
                if (len_q >= LINE_W'(TARGET_LEN) ||
                    item_i.rx_byte != target_char(len_q)) begin
                  match_d = 1'b0;
                end
                len_d = len_q + LINE_W'(1);
              end else begin
                // overflow: drop the byte, restart empty
                len_d   = '0;
                match_d = 1'b1;
              end
            end
          end
        end
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_SCAN;
      magic_q <= 2'd0;
      len_q   <= '0;
      match_q <= 1'b1;
    end else if (fire_i) begin
      phase_q <= phase_d;
      magic_q <= magic_d;
      len_q   <= len_d;
      match_q <= match_d;
    end
  end

  a_len_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    len_q <= LINE_W'(LINE_SLOTS - 1))
    else $error("line length beyond buffer");

  a_cmd_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && phase_q == PH_CMD && !item_i.cmd |=> phase_q != PH_CMD)
    else $error("command phase held after a command byte");

  a_magic_reset: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && phase_q == PH_SCAN && phase_d == PH_CMD |=> magic_q == 2'd0 && len_q == '0)
    else $error("magic completion left stale match state");

  a_cmd_phase_no_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_CMD |-> len_q == '0 && match_q)
    else $error("line state not cleared while awaiting command");

endmodule

`default_nettype wire

// ----- design/scd_pkg_top_placeholder.sv -----
// Result register stage of the serial command detector: holds one result for the sink.
// Depends on scd_pkg.
`timescale 1ns / 1ps
`default_nettype none

module scd_out_stage import scd_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     load_i,
  input  wire scd_res_t res_i,
  input  wire logic     ready_i,
  output logic          valid_o,
  output scd_res_t      res_o
);

  logic     valid_q;
  scd_res_t res_q;

  // occupancy: filled on load, emptied on a transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

  a_payload_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.event_res != EV_PAYLOAD |-> res_q.payload == 8'd0)
    else $error("payload set on a non-payload result");

  a_command_only: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q && res_q.event_res != EV_DISPATCH |-> res_q.command == 3'd0)
    else $error("command set on a non-dispatch result");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_i |-> !valid_q || ready_i)
    else $error("result register overwritten before transfer");

endmodule

`default_nettype wire

// ----- design/serial_command_detector_top.sv -----
// Serial command detector: one byte or handler-done item in, at most one result out.
// An item is registered on transfer, processed by the core when it leaves the input register
// and its result held in an output register. One item per clock is sustained while the sink
// takes results. The sink may stall: the input register then holds only while its item has
// a result and the output register is full. No clearing pass.
// Depends on scd_pkg, scd_in_if, scd_out_if, scd_core and scd_out_stage.
`timescale 1ns / 1ps
`default_nettype none

module serial_command_detector_top import scd_pkg::*; (
  input wire logic clk_i,
  input wire logic rst_ni,
  scd_in_if.sink   in_i,
  scd_out_if.source out_o
);

  logic      s1_valid_q;
  scd_item_t s1_item_q;
  logic      s1_fire;
  logic      res_valid;
  scd_res_t  res;
  logic      out_valid;
  scd_res_t  out_res;
  logic      out_free;

  // output register can take a result this cycle
  assign out_free   = !out_valid || out_o.ready;
  assign s1_fire    = s1_valid_q && (!res_valid || out_free);
  assign in_i.ready = !s1_valid_q || s1_fire;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      s1_item_q.cmd     <= in_i.cmd;
      s1_item_q.rx_byte <= in_i.rx_byte;
      s1_item_q.allowed <= in_i.allowed;
    end
  end

  scd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (s1_item_q),
    .fire_i      (s1_fire),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  scd_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .load_i  (s1_fire && res_valid),
    .res_i   (res),
    .ready_i (out_o.ready),
    .valid_o (out_valid),
    .res_o   (out_res)
  );

  assign out_o.valid     = out_valid;
  assign out_o.event_res = out_res.event_res;
  assign out_o.command   = out_res.command;
  assign out_o.payload   = out_res.payload;

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_valid_q |-> in_i.ready)
    else $error("input stalled with empty input register");

  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_fire |-> res_valid && out_valid && !out_o.ready)
    else $error("input register held without a full output");

endmodule

`default_nettype wire

// ----- verif/serial_command_detector_top_tb.sv -----
// Testbench for serial_command_detector_top: directed and random byte streams with a
// cycle-free behavioural predictor, random idling on both channels and a long sink stall.
// Depends on scd_pkg, scd_in_if, scd_out_if and the detector RTL.
`timescale 1ns / 1ps

module serial_command_detector_top_tb;
  import scd_pkg::*;

  localparam int unsigned CLK_PERIOD   = 20;
  localparam int unsigned RESET_CYCLES = 11;
  localparam int unsigned RAND_ITEMS   = 1150;
  localparam int unsigned DRAIN_CYCLES = 8;
  localparam int unsigned HOLD_CYCLES  = 250;

  // fixed patterns, first character in the top byte
  localparam logic [31:0]               MAGIC_WORD  = "CMND";
  localparam logic [8*TARGET_LEN-1:0]   SHOT_LINE   = "CMD:SCREENSHOT";
  localparam logic [55:0]               CMD_LETTERS = "SAKWRNT";

  logic clk_i;
  logic rst_ni;

  scd_in_if  in_if ();
  scd_out_if out_if ();

  serial_command_detector_top u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // shared testbench state
  scd_res_t    expected_q[$];
  int unsigned mismatches;
  int unsigned items_sent;
  int unsigned hold_left;
  bit          idle_on;

  // predictor state
  logic [1:0]  pred_magic;
  int unsigned pred_line_len;
  bit          pred_line_ok;
  scd_phase_e  pred_phase;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #(CLK_PERIOD / 2) clk_i = ~clk_i;
  end

  // overall limit on simulated time
  initial begin
    #5ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  function automatic logic [7:0] magic_at(input int unsigned idx);
    return MAGIC_WORD[8*(3-idx) +: 8];
  endfunction

  function automatic logic [7:0] shot_at(input int unsigned idx);
    return SHOT_LINE[8*(TARGET_LEN-1-idx) +: 8];
  endfunction

  function automatic logic [7:0] letter_at(input int unsigned idx);
    return CMD_LETTERS[8*(6-idx) +: 8];
  endfunction

  function automatic void line_clear();
    pred_line_len = 0;
    pred_line_ok  = 1'b1;
  endfunction

  // advance the detector state by one item; returns 1 when a result is due
  function automatic bit detect_item(input scd_item_t it, output scd_res_t res);
    bit hit;
    res = '0;
    if (pred_phase == PH_PAYLOAD) begin
      if (it.cmd) begin
        pred_phase = PH_SCAN;
        return 1'b0;
      end
      res.event_res = EV_PAYLOAD;
      res.payload   = it.rx_byte;
      return 1'b1;
    end
    if (it.cmd) return 1'b0;

    // command letter after the magic
    if (pred_phase == PH_CMD) begin
      pred_phase = PH_SCAN;
      if (it.rx_byte == letter_at(0)) begin
        res.event_res = it.allowed ? EV_DISPATCH : EV_REFUSED;
        return 1'b1;
      end
      for (int unsigned i = 1; i < 7; i++) begin
        if (it.rx_byte == letter_at(i)) begin
          pred_phase    = PH_PAYLOAD;
          res.event_res = EV_DISPATCH;
          res.command   = 3'(i);
          return 1'b1;
        end
      end
      res.event_res = EV_UNKNOWN;
      return 1'b1;
    end

    // magic match, restarting at one on a C
    pred_phase = PH_SCAN;
    if (it.rx_byte == magic_at(pred_magic)) begin
      if (pred_magic == 2'd3) begin
        pred_magic = 2'd0;
        line_clear();
        pred_phase = PH_CMD;
        return 1'b0;
      end
      pred_magic = pred_magic + 2'd1;
    end else begin
      pred_magic = (it.rx_byte == magic_at(0)) ? 2'd1 : 2'd0;
    end

    // line match
    if (it.rx_byte == CHAR_LF) begin
      hit = pred_line_ok && (pred_line_len == TARGET_LEN);
      line_clear();
      if (hit) res.event_res = EV_SHOT;
      return hit;
    end
    if (it.rx_byte == CHAR_CR) return 1'b0;
    if (pred_line_len + 1 < LINE_SLOTS) begin
      if (pred_line_len >= TARGET_LEN || it.rx_byte != shot_at(pred_line_len))
        pred_line_ok = 1'b0;
      pred_line_len++;
    end else begin
      line_clear();
    end
    return 1'b0;
  endfunction

  // offer one item after a random gap and wait for its transfer
  task automatic send_item(input logic cmd, input logic [7:0] data, input logic allow);
    int unsigned gap;
    scd_item_t   it;
    scd_res_t    res;
    gap = idle_on ? $urandom_range(0, 3) : 0;
    @(negedge clk_i);
    if (gap != 0) begin
      in_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid   = 1'b1;
    in_if.cmd     = cmd;
    in_if.rx_byte = data;
    in_if.allowed = allow;
    do @(posedge clk_i); while (!in_if.ready);
    it.cmd     = cmd;
    it.rx_byte = data;
    it.allowed = allow;
    // handler done outside the payload phase is ignored by the block
    if (!(cmd && pred_phase != PH_PAYLOAD)) items_sent++;
    if (detect_item(it, res)) expected_q.push_back(res);
  endtask

  task automatic send_byte(input logic [7:0] data, input logic allow);
    send_item(1'b0, data, allow);
  endtask

  task automatic send_done();
    send_item(1'b1, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
  endtask

  task automatic send_text(input string s, input logic allow);
    for (int i = 0; i < s.len(); i++) send_byte(s[i], allow);
  endtask

  // handler done while scanning
  task automatic test_done_when_idle();
    send_item(1'b1, 8'hFF, 1'b1);
  endtask

  // screenshot line with a carriage return inside
  task automatic test_screenshot_line();
    send_text("CMD:SCREEN", 1'b1);
    send_byte(CHAR_CR, 1'b1);
    send_text("SHOT", 1'b0);
    send_byte(CHAR_LF, 1'b0);
  endtask

  // status letter allowed and refused, magic restart on C, done while awaiting
  task automatic test_status_command();
    send_text("CMCMND", 1'b1);
    send_done();
    send_byte(letter_at(0), 1'b1);
    send_text("CMND", 1'b0);
    send_byte(letter_at(0), 1'b0);
  endtask

  // unknown command letter
  task automatic test_unknown_command();
    send_text("CMND", 1'b1);
    send_byte(8'h00, 1'b1);
  endtask

  // payload command with extreme payload bytes, closed by handler done
  task automatic test_payload_command();
    send_text("CMND", 1'b0);
    send_byte(letter_at(6), 1'b0);
    send_byte(8'hFF, 1'b1);
    send_byte(8'h00, 1'b0);
    send_done();
  endtask

  // long sink stall while payload bytes keep coming
  task automatic test_sink_hold();
    idle_on = 1'b0;
    send_text("CMND", 1'b1);
    send_byte(letter_at(2), 1'b1);
    hold_left = HOLD_CYCLES;
    repeat (24) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
    send_done();
    idle_on = 1'b1;
  endtask

  // random mix of command sequences, screenshot lines, long lines and noise
  task automatic test_random_stream();
    int unsigned start;
    int unsigned kind;
    int unsigned n;
    int unsigned pos;
    logic [7:0]  ch;
    bit          corrupt;
    start = items_sent;
    while (items_sent - start < RAND_ITEMS) begin
      idle_on = ($urandom_range(0, 7) != 0);
      kind    = $urandom_range(0, 99);
      if (kind < 40) begin
        // magic, letter, payload, handler done
        if ($urandom_range(0, 3) == 0) begin
          if ($urandom_range(0, 1) != 0) send_text("C", 1'($urandom_range(0, 1)));
          else send_text("CM", 1'($urandom_range(0, 1)));
        end
        send_text("CMND", 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 7) == 0) send_done();
        n  = $urandom_range(0, 8);
        ch = (n <= 6) ? letter_at(n) : 8'($urandom_range(0, 255));
        send_byte(ch, 1'($urandom_range(0, 1)));
        n = $urandom_range(0, 8);
        repeat (n) send_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        send_done();
      end else if (kind < 65) begin
        // screenshot line, sometimes broken
        corrupt = ($urandom_range(0, 3) == 0);
        pos     = $urandom_range(0, TARGET_LEN - 1);
        for (int unsigned i = 0; i < TARGET_LEN; i++) begin
          if ($urandom_range(0, 9) == 0) send_byte(CHAR_CR, 1'($urandom_range(0, 1)));
          ch = (corrupt && i == pos) ? 8'($urandom_range(0, 255)) : shot_at(i);
          send_byte(ch, 1'($urandom_range(0, 1)));
        end
        if ($urandom_range(0, 7) == 0) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'b1);
        send_byte(CHAR_LF, 1'($urandom_range(0, 1)));
      end else if (kind < 68) begin
        // line around the buffer size, then maybe a screenshot line
        n = $urandom_range(LINE_SLOTS - 4, LINE_SLOTS + 2);
        repeat (n) send_byte(8'($urandom_range(8'h20, 8'h7E)), 1'($urandom_range(0, 1)));
        if ($urandom_range(0, 1) == 0)
          for (int unsigned i = 0; i < TARGET_LEN; i++) send_byte(shot_at(i), 1'b1);
        send_byte(CHAR_LF, 1'b1);
      end else begin
        // noise, handler done included
        n = $urandom_range(1, 6);
        repeat (n)
          send_item(1'($urandom_range(0, 5) == 0), 8'($urandom_range(0, 255)),
                    1'($urandom_range(0, 1)));
      end
    end
  endtask

  // result sink: random stall per transfer, plus the long hold when requested
  initial begin : result_sink
    int unsigned stall_left;
    stall_left   = 0;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_left != 0) begin
        out_if.ready = 1'b0;
        hold_left--;
      end else if (stall_left != 0) begin
        out_if.ready = 1'b0;
        stall_left--;
      end else begin
        out_if.ready = 1'b1;
      end
      @(posedge clk_i);
      if (out_if.valid && out_if.ready) stall_left = idle_on ? $urandom_range(0, 3) : 0;
    end
  end

  // compare each result transfer with the oldest expectation
  always @(posedge clk_i) begin : result_check
    scd_res_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: event_res %0d command %0d payload %0h",
               out_if.event_res, out_if.command, out_if.payload);
        mismatches++;
      end else begin
        want = expected_q.pop_front();
        if (out_if.event_res !== want.event_res) begin
          $error("event_res: expected %0d, actual %0d", want.event_res, out_if.event_res);
          mismatches++;
        end
        if (out_if.command !== want.command) begin
          $error("command: expected %0d, actual %0d", want.command, out_if.command);
          mismatches++;
        end
        if (out_if.payload !== want.payload) begin
          $error("payload: expected %0h, actual %0h", want.payload, out_if.payload);
          mismatches++;
        end
      end
    end
  end

  // main sequence
  initial begin : main_seq
    mismatches    = 0;
    items_sent    = 0;
    hold_left     = 0;
    idle_on       = 1'b1;
    pred_magic    = 2'd0;
    pred_phase    = PH_SCAN;
    line_clear();
    in_if.valid   = 1'b0;
    in_if.cmd     = 1'b0;
    in_if.rx_byte = 8'h00;
    in_if.allowed = 1'b0;
    rst_ni        = 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(posedge clk_i);

    test_done_when_idle();
    test_screenshot_line();
    test_status_command();
    test_unknown_command();
    test_payload_command();
    test_sink_hold();
    test_random_stream();

    // drain outstanding results
    @(negedge clk_i);
    in_if.valid = 1'b0;
    idle_on     = 1'b1;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
design/scd_pkg.sv
design/scd_in_if.sv
design/scd_out_if.sv
design/scd_core.sv
design/scd_pkg_top_placeholder.sv
design/serial_command_detector_top.sv
verif/serial_command_detector_top_tb.sv
